FILE: rtl/sme_pkg.sv
package sme_pkg;

    // action codes of an input word
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    // register indexes on the configuration port
    localparam logic REG_HALF_PERIOD = 1'b0;
    localparam logic REG_CS_SETUP    = 1'b1;

    localparam int CNT_W  = 6;
    localparam int WAIT_W = 24;
    localparam int HP_W   = 16;
    localparam int TX_W   = 32;
    localparam int RD_W   = 16;

    localparam logic [HP_W-1:0]   HP_RESET    = 16'd1;
    localparam logic [WAIT_W-1:0] SETUP_RESET = 24'd1000000;

    // sequencer phases, one-hot
    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_SETUP = 6'b000010,
        PH_WLOW  = 6'b000100,
        PH_WHIGH = 6'b001000,
        PH_RHIGH = 6'b010000,
        PH_RLOW  = 6'b100000
    } phase_t;

    // classified word handed from front to engine
    typedef struct packed {
        logic             start_wr;
        logic             start_rd;
        logic [TX_W-1:0]  data;
        logic [CNT_W-1:0] cnt;
        logic             miso;
    } cmd_t;

    // one result word
    typedef struct packed {
        logic            cs_n;
        logic            sclk;
        logic            mosi;
        logic            busy;
        logic [RD_W-1:0] rdata;
        logic            done;
        logic            rejected;
    } res_t;

endpackage

FILE: rtl/sme_front.sv
module sme_front #(
    parameter int MAX_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  action,
    input  logic [31:0]                 write_data,
    input  logic [5:0]                  bit_count,
    input  logic                        miso_level,
    output logic                        cmd_valid,
    input  logic                        cmd_take,
    output sme_pkg::cmd_t               cmd
);

    sme_pkg::cmd_t mem_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    sme_pkg::cmd_t cls;
    logic          do_push, do_pop;

    // decode action and saturate the bit count
    always_comb
    begin
        cls.start_wr = 1'b0;
        cls.start_rd = 1'b0;
        case (sme_pkg::action_t'(action))
            sme_pkg::ACT_WRITE: cls.start_wr = 1'b1;
            sme_pkg::ACT_READ:  cls.start_rd = 1'b1;
            default:            ;
        endcase
        cls.data = write_data;
        cls.miso = miso_level;
        if ({26'd0, bit_count} > 32'(MAX_BITS))
            cls.cnt = sme_pkg::CNT_W'(MAX_BITS);
        else
            cls.cnt = bit_count;
    end

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    // two-entry queue toward the engine
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= cls;
    end

    assign cmd = mem_reg[rd_ptr_reg];

endmodule

FILE: rtl/sme_engine.sv
module sme_engine #(
    parameter int MAX_BITS   = 32,
    parameter int READ_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    output logic                               cmd_take,
    input  sme_pkg::cmd_t                      cmd,
    input  logic [sme_pkg::HP_W-1:0]           half_period,
    input  logic [sme_pkg::WAIT_W-1:0]         cs_setup,
    output logic                               empty,
    input  logic                               pop,
    output sme_pkg::res_t                      res
);

    sme_pkg::phase_t               phase_reg, phase_next;
    logic [sme_pkg::CNT_W-1:0]     bits_reg, bits_next;
    logic [sme_pkg::TX_W-1:0]      tx_reg, tx_next;
    logic [READ_WIDTH-1:0]         rx_reg, rx_next;
    logic [sme_pkg::WAIT_W-1:0]    wait_reg, wait_next;
    logic                          cs_reg, cs_next;
    logic                          clk_reg, clk_next;
    logic                          mosi_reg, mosi_next;
    logic                          rd_reg, rd_next;

    sme_pkg::res_t                 q_reg [2];
    logic                          qw_reg, qr_reg;
    logic [1:0]                    qc_reg, qc_next;
    logic                          q_pop;
    sme_pkg::res_t                 res_word;

    logic [sme_pkg::WAIT_W-1:0]    hp_load;
    logic                          rejected, done;
    logic [sme_pkg::CNT_W-1:0]     bits_dec;
    logic [sme_pkg::CNT_W-1:0]     idx;
    logic                          wait_end;
    logic [31:0]                   rx_wide;

    // step whenever a word waits and the result queue has room
    assign q_pop    = pop && (qc_reg != 2'd0);
    assign cmd_take = cmd_valid && ((qc_reg != 2'd2) || q_pop);
    assign hp_load  = (half_period == '0) ? sme_pkg::WAIT_W'(1)
                                          : sme_pkg::WAIT_W'(half_period);
    assign wait_end = (wait_reg <= sme_pkg::WAIT_W'(1));

    // tx bit for a given remaining count, zero past the data word
    function automatic logic tx_pick(input logic [sme_pkg::CNT_W-1:0] left,
                                     input logic [sme_pkg::TX_W-1:0] sh);
        logic [sme_pkg::CNT_W-1:0] i;
        i = left - sme_pkg::CNT_W'(1);
        if (left == '0 || i >= sme_pkg::CNT_W'(sme_pkg::TX_W))
            return 1'b0;
        return sh[i[4:0]];
    endfunction

    // pin sequencer
    always_comb
    begin
        phase_next = phase_reg;
        bits_next  = bits_reg;
        tx_next    = tx_reg;
        rx_next    = rx_reg;
        wait_next  = wait_reg;
        cs_next    = cs_reg;
        clk_next   = clk_reg;
        mosi_next  = mosi_reg;
        rd_next    = rd_reg;
        done       = 1'b0;
        rejected   = (cmd.start_wr || cmd.start_rd) && (phase_reg != sme_pkg::PH_IDLE);
        bits_dec   = bits_reg - sme_pkg::CNT_W'(1);
        idx        = bits_dec;

        if (cmd.start_wr && !rejected)
        begin
            rd_next    = 1'b0;
            tx_next    = cmd.data;
            bits_next  = cmd.cnt;
            cs_next    = 1'b0;
            wait_next  = cs_setup;
            phase_next = sme_pkg::PH_SETUP;
        end
        else if (cmd.start_rd && !rejected)
        begin
            rd_next   = 1'b1;
            rx_next   = '0;
            bits_next = cmd.cnt;
            cs_next   = 1'b0;
            if (cmd.cnt == '0)
            begin
                mosi_next  = 1'b0;
                clk_next   = 1'b0;
                cs_next    = 1'b1;
                phase_next = sme_pkg::PH_IDLE;
                done       = 1'b1;
            end
            else
            begin
                clk_next   = 1'b1;
                wait_next  = hp_load;
                phase_next = sme_pkg::PH_RHIGH;
            end
        end
        else
        begin
            // timed phases count down, a wait ends at one or zero
            if (phase_reg != sme_pkg::PH_SETUP && phase_reg != sme_pkg::PH_IDLE)
                wait_next = wait_end ? '0 : wait_reg - sme_pkg::WAIT_W'(1);
            case (phase_reg)
                sme_pkg::PH_IDLE: ;
                sme_pkg::PH_SETUP:
                begin
                    if (wait_reg != '0)
                        wait_next = wait_reg - sme_pkg::WAIT_W'(1);
                    else if (bits_reg == '0)
                    begin
                        mosi_next  = 1'b0;
                        clk_next   = 1'b0;
                        cs_next    = 1'b1;
                        phase_next = sme_pkg::PH_IDLE;
                    end
                    else
                    begin
                        mosi_next  = tx_pick(bits_reg, tx_reg);
                        wait_next  = hp_load;
                        phase_next = sme_pkg::PH_WLOW;
                    end
                end
                sme_pkg::PH_WLOW:
                begin
                    if (wait_end)
                    begin
                        clk_next   = 1'b1;
                        wait_next  = hp_load;
                        phase_next = sme_pkg::PH_WHIGH;
                    end
                end
                sme_pkg::PH_WHIGH:
                begin
                    if (wait_end)
                    begin
                        clk_next  = 1'b0;
                        bits_next = bits_dec;
                        if (bits_dec != '0)
                        begin
                            mosi_next  = tx_pick(idx, tx_reg);
                            wait_next  = hp_load;
                            phase_next = sme_pkg::PH_WLOW;
                        end
                        else
                        begin
                            mosi_next  = 1'b0;
                            cs_next    = 1'b1;
                            phase_next = sme_pkg::PH_IDLE;
                        end
                    end
                end
                sme_pkg::PH_RHIGH:
                begin
                    if (wait_end)
                    begin
                        rx_next    = {rx_reg[READ_WIDTH-2:0], cmd.miso};
                        clk_next   = 1'b0;
                        wait_next  = hp_load;
                        phase_next = sme_pkg::PH_RLOW;
                    end
                end
                sme_pkg::PH_RLOW:
                begin
                    if (wait_end)
                    begin
                        bits_next = bits_dec;
                        if (bits_dec != '0)
                        begin
                            clk_next   = 1'b1;
                            wait_next  = hp_load;
                            phase_next = sme_pkg::PH_RHIGH;
                        end
                        else
                        begin
                            mosi_next  = 1'b0;
                            clk_next   = 1'b0;
                            cs_next    = 1'b1;
                            phase_next = sme_pkg::PH_IDLE;
                            done       = 1'b1;
                        end
                    end
                end
                default: phase_next = sme_pkg::PH_IDLE;
            endcase
        end

        rx_wide            = 32'(rx_next);
        res_word.cs_n      = cs_next;
        res_word.sclk      = clk_next;
        res_word.mosi      = mosi_next;
        res_word.busy      = (phase_next != sme_pkg::PH_IDLE);
        res_word.rdata     = rx_wide[sme_pkg::RD_W-1:0];
        res_word.done      = done;
        res_word.rejected  = rejected;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sme_pkg::PH_IDLE;
            bits_reg  <= '0;
            tx_reg    <= '0;
            rx_reg    <= '0;
            wait_reg  <= '0;
            cs_reg    <= 1'b1;
            clk_reg   <= 1'b0;
            mosi_reg  <= 1'b0;
            rd_reg    <= 1'b0;
        end
        else if (cmd_take)
        begin
            phase_reg <= phase_next;
            bits_reg  <= bits_next;
            tx_reg    <= tx_next;
            rx_reg    <= rx_next;
            wait_reg  <= wait_next;
            cs_reg    <= cs_next;
            clk_reg   <= clk_next;
            mosi_reg  <= mosi_next;
            rd_reg    <= rd_next;
        end
    end

    // two-entry result queue
    assign qc_next = qc_reg + {1'b0, cmd_take} - {1'b0, q_pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qw_reg <= 1'b0;
            qr_reg <= 1'b0;
            qc_reg <= 2'd0;
        end
        else
        begin
            qw_reg <= qw_reg ^ cmd_take;
            qr_reg <= qr_reg ^ q_pop;
            qc_reg <= qc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
            q_reg[qw_reg] <= res_word;
    end

    assign empty = (qc_reg == 2'd0);
    assign res   = q_reg[qr_reg];

    // idle pins are released
    a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == sme_pkg::PH_IDLE |-> cs_reg && !clk_reg && !mosi_reg)
        else $error("pins not released while idle");

    // chip select held low through a transaction
    a_busy_cs: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != sme_pkg::PH_IDLE |-> !cs_reg)
        else $error("cs_n high during transaction");

    // result queue never overfills
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qc_reg != 2'd3)
        else $error("result queue overflow");

    // read phases only run a read
    a_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == sme_pkg::PH_RHIGH || phase_reg == sme_pkg::PH_RLOW) |-> rd_reg)
        else $error("read phase without read transaction");

    // remaining bit count stays within the limit
    a_bits: assert property (@(posedge clk) disable iff (!rst_n)
        32'(bits_reg) <= 32'(MAX_BITS))
        else $error("bit count above limit");

endmodule

FILE: rtl/spi_master_bit_engine_core.sv
// channel | handshake          | word
// --------+--------------------+------------------------------------------------
// input   | push / full        | action, write_data, bit_count, miso_level
// result  | empty / pop        | cs_n, sclk, mosi, busy_res, read_data,
//         |                    | read_done, start_rejected
// config  | psel/penable/pready| paddr 0 half_period_ticks, 4 cs_setup_ticks
//
// one tick word is taken per cycle while the result queue has room and its
// result word is queued the same cycle; the single engine step sets that rate,
// two-entry queues sit in front of and behind it so either side can stall alone
// reset: sequencer cs_n high, sclk and mosi low, idle, both queues empty
// registers come up at half period 1 and setup 1000000 ticks
module spi_master_bit_engine_core #(
    parameter int MAX_BITS   = 32,
    parameter int READ_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  action,
    input  logic [31:0] write_data,
    input  logic [5:0]  bit_count,
    input  logic        miso_level,
    output logic        empty,
    input  logic        pop,
    output logic        cs_n,
    output logic        sclk,
    output logic        mosi,
    output logic        busy_res,
    output logic [15:0] read_data,
    output logic        read_done,
    output logic        start_rejected,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [sme_pkg::HP_W-1:0]   hp_reg;
    logic [sme_pkg::WAIT_W-1:0] setup_reg;
    logic                       cfg_wr;
    logic                       cmd_valid, cmd_take;
    sme_pkg::cmd_t              cmd;
    sme_pkg::res_t              res;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_reg    <= sme_pkg::HP_RESET;
            setup_reg <= sme_pkg::SETUP_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == sme_pkg::REG_HALF_PERIOD)
                hp_reg <= pwdata[sme_pkg::HP_W-1:0];
            else
                setup_reg <= pwdata[sme_pkg::WAIT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == sme_pkg::REG_CS_SETUP) ? 32'(setup_reg) : 32'(hp_reg);

    sme_front #(
        .MAX_BITS (MAX_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .action     (action),
        .write_data (write_data),
        .bit_count  (bit_count),
        .miso_level (miso_level),
        .cmd_valid  (cmd_valid),
        .cmd_take   (cmd_take),
        .cmd        (cmd)
    );

    sme_engine #(
        .MAX_BITS   (MAX_BITS),
        .READ_WIDTH (READ_WIDTH)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_take    (cmd_take),
        .cmd         (cmd),
        .half_period (hp_reg),
        .cs_setup    (setup_reg),
        .empty       (empty),
        .pop         (pop),
        .res         (res)
    );

    // result word fields
    assign cs_n           = res.cs_n;
    assign sclk           = res.sclk;
    assign mosi           = res.mosi;
    assign busy_res       = res.busy;
    assign read_data      = res.rdata;
    assign read_done      = res.done;
    assign start_rejected = res.rejected;

endmodule
